// File: rtl/swds_pkg.sv
// swds_pkg: shared types and constants for the stall watchdog sampler.
// Holds the request, response and configuration structs and reset values.
// No dependencies.
package swds_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned LimitWidth  = 24;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [LimitWidth-1:0] ThresholdReset = 24'd120000;
   localparam logic [CountWidth-1:0] BudgetReset    = 16'd200;
   localparam logic [LimitWidth-1:0] GapReset       = 24'd250000;

   localparam logic [CsrIdxWidth-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BUDGET    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_GAP   = 2'd2;

   localparam logic OP_FRAME_BEGIN = 1'b0;
   localparam logic OP_TICK        = 1'b1;

   typedef struct packed {
      logic                 opcode;
      logic [TimeWidth-1:0] timestamp_us;
      logic                 report_busy;
   } req_type;

   typedef struct packed {
      logic                  sample_now;
      logic [TimeWidth-1:0]  stalled_us;
      logic [CountWidth-1:0] samples_taken;
      logic [TimeWidth-1:0]  worst_stall_us;
   } rsp_type;

   typedef struct packed {
      logic [LimitWidth-1:0] stall_threshold_us;
      logic [CountWidth-1:0] sample_budget;
      logic [LimitWidth-1:0] min_gap_us;
   } cfg_type;

endpackage

// File: rtl/swds_csr.sv
// swds_csr: configuration registers of the stall watchdog sampler.
// Depends on swds_pkg for cfg_type, register indexes and reset values.
module swds_csr import swds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [LimitWidth-1:0]  csr_wdata,
   output logic                   csr_ready,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_in.stall_threshold_us = csr_wdata;
            CSR_BUDGET:    cfg_in.sample_budget      = csr_wdata[CountWidth-1:0];
            CSR_MIN_GAP:   cfg_in.min_gap_us         = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_threshold_us <= ThresholdReset;
         cfg_ff.sample_budget      <= BudgetReset;
         cfg_ff.min_gap_us         <= GapReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/swds_eval.sv
// swds_eval: stall tracking state and the per-event decision logic.
// Depends on swds_pkg; state advances when the top level commits an event.
module swds_eval import swds_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    commit,
   output rsp_type result
);

   logic [TimeWidth-1:0]  frame_start_ff, frame_start_in;
   logic                  frame_seen_ff, frame_seen_in;
   logic                  in_flight_ff, in_flight_in;
   logic [TimeWidth-1:0]  last_sample_ff, last_sample_in;
   logic                  sample_seen_ff, sample_seen_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [TimeWidth-1:0]  worst_ff, worst_in;

   logic                 is_tick;
   logic [TimeWidth-1:0] age;
   logic [TimeWidth-1:0] gap;
   logic                 gap_ok;
   logic                 pass;
   logic                 fire;

   always_comb begin
      is_tick = (item.opcode == OP_TICK);
      age     = (is_tick && frame_seen_ff) ? item.timestamp_us - frame_start_ff : '0;
      gap     = item.timestamp_us - last_sample_ff;
      gap_ok  = !sample_seen_ff ||
                (gap >= {{(TimeWidth-LimitWidth){1'b0}}, cfg.min_gap_us});
      pass    = is_tick && frame_seen_ff && (cfg.sample_budget != '0) &&
                (age >= {{(TimeWidth-LimitWidth){1'b0}}, cfg.stall_threshold_us}) &&
                !item.report_busy && !in_flight_ff;
      fire    = pass && (count_ff < cfg.sample_budget) && gap_ok;

      frame_start_in = frame_start_ff;
      frame_seen_in  = frame_seen_ff;
      in_flight_in   = in_flight_ff;
      last_sample_in = last_sample_ff;
      sample_seen_in = sample_seen_ff;
      count_in       = count_ff;
      worst_in       = worst_ff;

      if (!is_tick) begin
         frame_start_in = item.timestamp_us;
         frame_seen_in  = 1'b1;
         in_flight_in   = 1'b0;
      end else if (pass) begin
         in_flight_in = 1'b1;
      end
      if (fire) begin
         count_in       = count_ff + 1'b1;
         last_sample_in = item.timestamp_us;
         sample_seen_in = 1'b1;
         if (age > worst_ff) begin
            worst_in = age;
         end
      end

      result.sample_now     = fire;
      result.stalled_us     = age;
      result.samples_taken  = count_in;
      result.worst_stall_us = worst_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= '0;
         frame_seen_ff  <= 1'b0;
         in_flight_ff   <= 1'b0;
         last_sample_ff <= '0;
         sample_seen_ff <= 1'b0;
         count_ff       <= '0;
         worst_ff       <= '0;
      end else if (commit) begin
         frame_start_ff <= frame_start_in;
         frame_seen_ff  <= frame_seen_in;
         in_flight_ff   <= in_flight_in;
         last_sample_ff <= last_sample_in;
         sample_seen_ff <= sample_seen_in;
         count_ff       <= count_in;
         worst_ff       <= worst_in;
      end
   end

endmodule

// File: rtl/stall_watchdog_sampler.sv
// A request transfer passes the input register, then the response register;
// a response-side stall holds it there. One event per cycle unless the
// response side stalls; the response register frees the input side.
// Reset (synchronous): pipeline emptied, tracking state cleared to zero,
// configuration back to threshold 120000 us, budget 200, minimum gap 250000 us.
// Depends on swds_pkg, swds_csr and swds_eval.
module stall_watchdog_sampler import swds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [LimitWidth-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type result;

   logic    stage_valid_ff, stage_valid_in;
   req_type stage_data_ff, stage_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic out_open;
   logic commit;
   logic stage_open;

   swds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   swds_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (stage_data_ff),
      .commit (commit),
      .result (result)
   );

   always_comb begin
      out_open   = !rsp_valid_ff || !rsp_stall;
      commit     = stage_valid_ff && out_open;
      stage_open = !stage_valid_ff || commit;

      stage_valid_in = stage_open ? req_valid : stage_valid_ff;
      stage_data_in  = (stage_open && req_valid) ? req_data : stage_data_ff;
      rsp_valid_in   = out_open ? stage_valid_ff : rsp_valid_ff;
      rsp_data_in    = commit ? result : rsp_data_ff;
   end

   assign req_stall = !stage_open;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_data_ff <= stage_data_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// File: rtl/swds_checker.sv
// swds_checker: port-level checks for stall_watchdog_sampler, bound to the top.
// Depends on swds_pkg for rsp_type.
module swds_checker import swds_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_sample_worst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_now |->
         (rsp_data.worst_stall_us >= rsp_data.stalled_us) &&
         (rsp_data.samples_taken != '0))
      else $error("sample transfer without matching worst stall or count");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind stall_watchdog_sampler swds_checker u_swds_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
